[rtl/core/svmix_pkg.sv]
// Shared constants, codes and item types of the six-row shaped VCA mixer.
package svmix_pkg;

  // Field widths of the channels.
  localparam int RowW      = 3;
  localparam int VoiceW    = 4;
  localparam int SampleW   = 16;
  localparam int OutW      = 19;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 60;

  // Per-row register packing.
  localparam int PackedRows = 6;
  localparam int ShapeW     = 10;
  localparam int LevelW     = 10;
  localparam int ChanW      = 5;
  localparam int MaskW      = PackedRows;
  localparam int ShapeRegW  = PackedRows * ShapeW;
  localparam int LevelRegW  = PackedRows * LevelW;
  localparam int ChanRegW   = PackedRows * ChanW;

  // Arithmetic widths: x and gain terms are Q14 in 15 bits, level terms Q9 in 10 bits.
  localparam int XW        = 15;
  localparam int SmpW      = 17;
  localparam int AccW      = 19;
  localparam int MulW      = 29;
  localparam int ProdW     = 2 * MulW;
  localparam int DivSteps  = 16;
  localparam int DivCntW   = $clog2(DivSteps);
  localparam int DenW      = 18;

  localparam logic [XW-1:0]     XOne       = 15'd16384;
  localparam logic [LevelW-1:0] LevelUnity = 10'd512;
  localparam logic [ChanW-1:0]  ChanMax    = 5'd16;

  // Defaults of the top-level parameters.
  localparam int DefaultRows   = 6;
  localparam int DefaultVoices = 16;

  // Depth of the queue between classifier and arithmetic engine.
  localparam int QueueDepth = 2;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  // Register reset values: every level at unity, every row one channel.
  localparam logic [LevelRegW-1:0] LevelsReset   = 60'h802_0080_2008_0200;
  localparam logic [ChanRegW-1:0]  ChannelsReset = 30'h210_8421;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ROW_SHAPES    = 3'd0,
    CFG_ROW_LEVELS    = 3'd1,
    CFG_FINAL_ROW_MIX = 3'd2,
    CFG_IN_CONNECTED  = 3'd3,
    CFG_CV_CONNECTED  = 3'd4,
    CFG_OUT_CONNECTED = 3'd5,
    CFG_ROW_CHANNELS  = 3'd6
  } cfg_idx_e;

  // What the engine does with an item once its sample is known.
  typedef enum logic [2:0] {
    OP_EMIT     = 3'd0,  // emit the scaled sample
    OP_ACC      = 3'd1,  // add the scaled sample into the voice mix
    OP_MIX      = 3'd2,  // emit mix plus sample, then clear the mix
    OP_CLEAR    = 3'd3,  // clear the mix, emit nothing
    OP_EMIT_CLR = 3'd4   // emit the scaled sample, then clear the mix
  } op_e;

  typedef struct packed {
    logic [ShapeRegW-1:0] row_shapes;
    logic [LevelRegW-1:0] row_levels;
    logic                 final_row_mix;
    logic [MaskW-1:0]     in_conn;
    logic [MaskW-1:0]     cv_conn;
    logic [MaskW-1:0]     out_conn;
    logic [ChanRegW-1:0]  row_channels;
  } cfg_t;

  // One classified item as it travels through the queue.
  typedef struct packed {
    logic [RowW-1:0]          row;
    logic [VoiceW-1:0]        voice;
    logic [SampleW-1:0]       in_sample;
    logic [XW-1:0]            x;
    logic                     shape_pos;
    logic [ShapeW-1:0]        s;
    logic [LevelW-1:0]        lvl;
    logic                     in_conn;
    op_e                      op;
  } item_t;

endpackage

[rtl/core/svmix_if.sv]
// Valid/ready channel interfaces of the mixer: sample input, result output, register writes.
interface svmix_in_if import svmix_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [RowW-1:0]    row;
  logic [VoiceW-1:0]  voice;
  logic [SampleW-1:0] in_sample;
  logic [SampleW-1:0] cv_sample;

  modport source (output valid, output row, output voice, output in_sample,
                  output cv_sample, input ready);
  modport sink   (input valid, input row, input voice, input in_sample,
                  input cv_sample, output ready);
endinterface

interface svmix_out_if import svmix_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [RowW-1:0]   out_row;
  logic [VoiceW-1:0] out_voice;
  logic [OutW-1:0]   out_sample;

  modport source (output valid, output out_row, output out_voice, output out_sample,
                  input ready);
  modport sink   (input valid, input out_row, input out_voice, input out_sample,
                  output ready);
endinterface

interface svmix_cfg_if import svmix_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/core/svmix_front.sv]
// Front end: accepts items, looks up the row settings and classifies each item.
module svmix_front import svmix_pkg::*; #(
  parameter int ROWS   = DefaultRows,
  parameter int VOICES = DefaultVoices
) (
  input  cfg_t            cfg_i,
  svmix_in_if.sink        in_i,
  input  logic            full_i,
  output logic            push_o,
  output item_t           item_o
);

  localparam int             NumSlots = 2 ** RowW;
  localparam logic [4:0]     RowLim   = 5'(ROWS);
  localparam logic [4:0]     LastRow  = 5'(ROWS - 1);
  localparam logic [4:0]     VoiceLim = 5'(VOICES);

  logic [ShapeW-1:0] shape_a [NumSlots];
  logic [LevelW-1:0] level_a [NumSlots];
  logic [ChanW-1:0]  chan_a  [NumSlots];
  logic [NumSlots-1:0] in_m, cv_m, out_m;
  logic [ChanW-1:0]  poly_max;
  logic              row_ok, is_final, outp, v_lt_ch, v_lt_mx, keep;
  logic signed [SampleW-1:0] cv;
  logic signed [ShapeW-1:0]  shape;
  logic [LevelW-1:0] lvl_raw;
  op_e               op;

  assign in_m  = NumSlots'(cfg_i.in_conn);
  assign cv_m  = NumSlots'(cfg_i.cv_conn);
  assign out_m = NumSlots'(cfg_i.out_conn);

  // Unpack the per-row fields; rows past the packed six read as zero shape and level, one channel.
  always_comb begin
    logic [ChanW-1:0] c;
    for (int k = 0; k < NumSlots; k++) begin
      c = '0;
      if (k < PackedRows) begin
        shape_a[k] = cfg_i.row_shapes[k*ShapeW +: ShapeW];
        level_a[k] = cfg_i.row_levels[k*LevelW +: LevelW];
        c          = cfg_i.row_channels[k*ChanW +: ChanW];
      end else begin
        shape_a[k] = '0;
        level_a[k] = '0;
      end
      if (!in_m[k]) begin
        chan_a[k] = 5'd1;
      end else begin
        if (c == '0) c = 5'd1;
        if (c > ChanMax) c = ChanMax;
        if (c > VoiceLim) c = VoiceLim;
        chan_a[k] = c;
      end
    end
  end

  // Largest polyphony among rows feeding the final row's mix.
  always_comb begin
    poly_max = 5'd1;
    for (int k = 0; k < NumSlots; k++) begin
      if (k < ROWS && in_m[k] && (k == ROWS - 1 || !out_m[k]) && chan_a[k] > poly_max) begin
        poly_max = chan_a[k];
      end
    end
  end

  assign row_ok   = ({2'b00, in_i.row} < RowLim) && ({1'b0, in_i.voice} < VoiceLim);
  assign is_final = ({2'b00, in_i.row} == LastRow);
  assign outp     = out_m[in_i.row];
  assign v_lt_ch  = {1'b0, in_i.voice} < chan_a[in_i.row];
  assign v_lt_mx  = {1'b0, in_i.voice} < poly_max;

  always_comb begin
    keep = 1'b0;
    op   = OP_CLEAR;
    if (row_ok) begin
      if (!is_final) begin
        if (outp) begin
          if (v_lt_ch) begin
            keep = 1'b1;
            op   = OP_EMIT;
          end
        end else if (cfg_i.final_row_mix) begin
          keep = 1'b1;
          op   = OP_ACC;
        end
      end else begin
        // The final row always clears the mix, so it always goes on.
        keep = 1'b1;
        if (outp && cfg_i.final_row_mix && v_lt_mx) begin
          op = OP_MIX;
        end else if (outp && !cfg_i.final_row_mix && v_lt_ch) begin
          op = OP_EMIT_CLR;
        end else begin
          op = OP_CLEAR;
        end
      end
    end
  end

  assign cv      = $signed(in_i.cv_sample);
  assign shape   = $signed(shape_a[in_i.row]);
  assign lvl_raw = level_a[in_i.row];

  always_comb begin
    item_o           = '0;
    item_o.row       = in_i.row;
    item_o.voice     = in_i.voice;
    item_o.in_sample = in_i.in_sample;
    item_o.in_conn   = in_m[in_i.row];
    item_o.op        = op;
    if (!cv_m[in_i.row]) begin
      item_o.x = XOne;
    end else if (cv <= 0) begin
      item_o.x = '0;
    end else if (cv >= $signed({1'b0, XOne})) begin
      item_o.x = XOne;
    end else begin
      item_o.x = cv[XW-1:0];
    end
    item_o.shape_pos = (shape > 0);
    item_o.s         = (shape > 0) ? shape_a[in_i.row] : ShapeW'(-shape);
    item_o.lvl       = (lvl_raw > LevelUnity) ? LevelUnity : lvl_raw;
  end

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i && keep;

endmodule

[rtl/core/svmix_fifo.sv]
// Short item queue that decouples the classifier from the arithmetic engine.
module svmix_fifo import svmix_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  empty_o,
  output item_t item_o
);

  item_t             mem_q [QueueDepth];
  logic [QPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]  cnt_q;

  localparam logic [QPtrW-1:0] LastPtr = QPtrW'(QueueDepth - 1);
  localparam logic [QCntW-1:0] FullCnt = QCntW'(QueueDepth);

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

[rtl/core/svmix_back.sv]
// Back end: sequenced gain arithmetic on one shared multiplier, mix accumulator and result register.
module svmix_back import svmix_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         empty_i,
  input  item_t        item_i,
  output logic         pop_o,
  svmix_out_if.source  out_o
);

  typedef enum logic [11:0] {
    ST_IDLE = 12'b0000_0000_0001,
    ST_DIV  = 12'b0000_0000_0010,
    ST_SQ1  = 12'b0000_0000_0100,
    ST_SQ2  = 12'b0000_0000_1000,
    ST_LIN  = 12'b0000_0001_0000,
    ST_TERM = 12'b0000_0010_0000,
    ST_GAIN = 12'b0000_0100_0000,
    ST_LVL  = 12'b0000_1000_0000,
    ST_TSC  = 12'b0001_0000_0000,
    ST_SMP  = 12'b0010_0000_0000,
    ST_SCL  = 12'b0100_0000_0000,
    ST_FIN  = 12'b1000_0000_0000
  } state_e;

  localparam logic [DivCntW-1:0] DivLast = DivCntW'(DivSteps - 1);
  localparam logic signed [AccW:0] AccMax = {2'b00, {(AccW-1){1'b1}}};
  localparam logic signed [AccW:0] AccMin = {2'b11, {(AccW-1){1'b0}}};

  state_e               state_q, state_d;
  item_t                item_q;
  logic [DivCntW-1:0]   cnt_q;
  logic [DenW-1:0]      den_q, rem_q;
  logic [DivSteps-1:0]  quo_q;
  logic [ProdW-1:0]     mul_q, prod;
  logic [MulW-1:0]      mul_a, mul_b;
  logic [XW-1:0]        term_q, g_q, t_q;
  logic [24:0]          sum_q, gsum, tsum;
  logic [29:0]          rnd;
  logic [17:0]          diff;
  logic signed [SmpW-1:0] smp_q;
  logic signed [AccW-1:0] acc_q;
  logic signed [AccW:0]   mix_sum;
  logic [AccW-1:0]      mix_sat;
  logic                 out_valid_q;
  logic [RowW-1:0]      out_row_q;
  logic [VoiceW-1:0]    out_voice_q;
  logic [OutW-1:0]      out_sample_q;
  logic                 needs_smp, emit_now, out_free, fin_go;
  logic [DenW-1:0]      den_w, x11;
  logic [31:0]          num_w;
  logic [DenW:0]        div_sh;
  logic                 div_ge;
  logic [ProdW-1:0]     x4_rnd;

  // Divider setup for the log term: 11x*16384 + den/2 over den = 10x + 16384.
  assign den_w = (DenW'(item_i.x) << 3) + (DenW'(item_i.x) << 1) + DenW'(XOne);
  assign x11   = (DenW'(item_i.x) << 3) + (DenW'(item_i.x) << 1) + DenW'(item_i.x);
  assign num_w = {x11, 14'b0} + 32'(den_w >> 1);

  assign needs_smp = (item_i.op != OP_CLEAR) && item_i.in_conn;
  assign pop_o     = (state_q == ST_IDLE) && !empty_i;

  assign div_sh = {rem_q, quo_q[DivSteps-1]};
  assign div_ge = (div_sh >= {1'b0, den_q});

  // Operand selection for the one shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_SQ1: begin
        mul_a = MulW'(item_q.x);
        mul_b = MulW'(item_q.x);
      end
      ST_SQ2: begin
        mul_a = mul_q[MulW-1:0];
        mul_b = mul_q[MulW-1:0];
      end
      ST_LIN: begin
        mul_a = MulW'(item_q.x);
        mul_b = MulW'(LevelUnity - item_q.s);
      end
      ST_TERM: begin
        mul_a = MulW'(term_q);
        mul_b = MulW'(item_q.s);
      end
      ST_LVL: begin
        mul_a = MulW'(g_q);
        mul_b = MulW'(item_q.lvl);
      end
      ST_SMP: begin
        // Offset binary keeps the product non-negative.
        mul_a = MulW'(item_q.in_sample ^ 16'h8000);
        mul_b = MulW'(t_q);
      end
      default: begin
      end
    endcase
  end

  assign prod   = mul_a * mul_b;
  assign x4_rnd = mul_q + (ProdW'(1) << 41);
  assign gsum   = sum_q + mul_q[24:0];
  assign tsum   = mul_q[24:0] + 25'd256;
  assign rnd    = mul_q[29:0] + 30'd8192;
  assign diff   = {2'b00, rnd[29:14]} - {2'b00, t_q, 1'b0};

  assign mix_sum = {acc_q[AccW-1], acc_q} + (AccW+1)'(smp_q);
  always_comb begin
    if (mix_sum > AccMax) begin
      mix_sat = AccMax[AccW-1:0];
    end else if (mix_sum < AccMin) begin
      mix_sat = AccMin[AccW-1:0];
    end else begin
      mix_sat = mix_sum[AccW-1:0];
    end
  end

  assign emit_now = (item_q.op == OP_EMIT) || (item_q.op == OP_MIX) ||
                    (item_q.op == OP_EMIT_CLR);
  assign out_free = !out_valid_q || out_o.ready;
  assign fin_go   = (state_q == ST_FIN) && (!emit_now || out_free);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          if (!needs_smp) begin
            state_d = ST_FIN;
          end else if (item_i.shape_pos) begin
            state_d = ST_DIV;
          end else begin
            state_d = ST_SQ1;
          end
        end
      end
      ST_DIV:  if (cnt_q == DivLast) state_d = ST_LIN;
      ST_SQ1:  state_d = ST_SQ2;
      ST_SQ2:  state_d = ST_LIN;
      ST_LIN:  state_d = ST_TERM;
      ST_TERM: state_d = ST_GAIN;
      ST_GAIN: state_d = ST_LVL;
      ST_LVL:  state_d = ST_TSC;
      ST_TSC:  state_d = ST_SMP;
      ST_SMP:  state_d = ST_SCL;
      ST_SCL:  state_d = ST_FIN;
      ST_FIN:  if (fin_go) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop_o) begin
        cnt_q <= '0;
      end else if (state_q == ST_DIV) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (out_o.valid && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (fin_go) begin
        case (item_q.op)
          OP_ACC:                       acc_q <= mix_sat;
          OP_MIX, OP_CLEAR, OP_EMIT_CLR: acc_q <= '0;
          default: begin
          end
        endcase
        if (emit_now) begin
          out_valid_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      item_q <= item_i;
      smp_q  <= '0;
      den_q  <= den_w;
      rem_q  <= DenW'(num_w[31:16]);
      quo_q  <= num_w[15:0];
    end
    if (state_q == ST_DIV) begin
      rem_q <= div_ge ? DenW'(div_sh - {1'b0, den_q}) : div_sh[DenW-1:0];
      quo_q <= {quo_q[DivSteps-2:0], div_ge};
    end
    if (state_q == ST_SQ1 || state_q == ST_SQ2 || state_q == ST_LIN ||
        state_q == ST_TERM || state_q == ST_LVL || state_q == ST_SMP) begin
      mul_q <= prod;
    end
    if (state_q == ST_LIN) begin
      term_q <= item_q.shape_pos ? quo_q[XW-1:0] : x4_rnd[42 +: XW];
    end
    if (state_q == ST_TERM) begin
      sum_q <= mul_q[24:0] + 25'd256;
    end
    if (state_q == ST_GAIN) begin
      g_q <= gsum[23:9];
    end
    if (state_q == ST_TSC) begin
      t_q <= tsum[23:9];
    end
    if (state_q == ST_SCL) begin
      smp_q <= diff[SmpW-1:0];
    end
    if (fin_go && emit_now) begin
      out_row_q    <= item_q.row;
      out_voice_q  <= item_q.voice;
      out_sample_q <= (item_q.op == OP_MIX) ? mix_sat : OutW'(smp_q);
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.out_row    = out_row_q;
  assign out_o.out_voice  = out_voice_q;
  assign out_o.out_sample = out_sample_q;

endmodule

[rtl/core/six_row_shaped_vca_mixer_top.sv]
// Top level of the six-row shaped VCA mixer: registers, classifier, queue and engine.
// Flat or exponential shapes run the sequenced gain arithmetic; logarithmic shapes first
// run a one-bit-per-cycle divider; items that skip the arithmetic go straight to the result.
// The engine finishes one item before taking the next; the front takes an item every cycle
// until the two-entry queue is full.
// Reset (rst_ni low, asynchronous) restores register defaults, clears mix, queue and result.
module six_row_shaped_vca_mixer_top import svmix_pkg::*; #(
  parameter int ROWS   = DefaultRows,
  parameter int VOICES = DefaultVoices
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  svmix_in_if.sink    in_i,
  svmix_out_if.source out_o,
  svmix_cfg_if.sink   cfg_i
);

  cfg_t  cfg_q;
  item_t front_item, queue_item;
  logic  push, full, pop, empty;

  // Register writes are always taken; the user must write them only while the block is idle,
  // which the block does not enforce, so items already classified never see a half-written setting.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.row_shapes    <= '0;
      cfg_q.row_levels    <= LevelsReset;
      cfg_q.final_row_mix <= 1'b1;
      cfg_q.in_conn       <= '0;
      cfg_q.cv_conn       <= '0;
      cfg_q.out_conn      <= '0;
      cfg_q.row_channels  <= ChannelsReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_ROW_SHAPES:    cfg_q.row_shapes    <= cfg_i.data[ShapeRegW-1:0];
        CFG_ROW_LEVELS:    cfg_q.row_levels    <= cfg_i.data[LevelRegW-1:0];
        CFG_FINAL_ROW_MIX: cfg_q.final_row_mix <= cfg_i.data[0];
        CFG_IN_CONNECTED:  cfg_q.in_conn       <= cfg_i.data[MaskW-1:0];
        CFG_CV_CONNECTED:  cfg_q.cv_conn       <= cfg_i.data[MaskW-1:0];
        CFG_OUT_CONNECTED: cfg_q.out_conn      <= cfg_i.data[MaskW-1:0];
        CFG_ROW_CHANNELS:  cfg_q.row_channels  <= cfg_i.data[ChanRegW-1:0];
        default: begin
          // Indexes past the register list are ignored.
        end
      endcase
    end
  end

  // The front drops out-of-range items and items that neither emit nor touch the
  // mix; everything else is tagged with its operation and the row's settings.
  svmix_front #(
    .ROWS   (ROWS),
    .VOICES (VOICES)
  ) u_front (
    .cfg_i  (cfg_q),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .item_o (front_item)
  );

  // The queue lets the front keep taking items while the engine is busy.
  svmix_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .item_o  (queue_item)
  );

  // The engine works one item at a time in item order, so the mix accumulator
  // always sees rows in the order they arrived. Its result register lets it
  // start on the next item while a result waits to be taken.
  svmix_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .item_i  (queue_item),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

[rtl/core/svmix_checker.sv]
// Port-level checks of the mixer and their binding to the top level.
module svmix_checker import svmix_pkg::*; #(
  parameter int ROWS = DefaultRows
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [RowW-1:0]   out_row_i,
  input logic [VoiceW-1:0] out_voice_i,
  input logic [OutW-1:0]   out_sample_i,
  input logic              cfg_valid_i,
  input logic              cfg_ready_i
);

  logic signed [OutW-1:0] smp;
  assign smp = $signed(out_sample_i);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn before it was taken");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_row_i) && $stable(out_voice_i) &&
    $stable(out_sample_i))
    else $error("stalled result changed");

  // The queue only fills through accepted items.
  a_ready_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_i) |-> $past(in_valid_i && in_ready_i))
    else $error("input stalled without a preceding accept");

  // Rows other than the final one only ever emit a single scaled sample.
  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (int'(out_row_i) != ROWS - 1) |->
    (smp >= -19'sd32768) && (smp <= 19'sd32767))
    else $error("non-final row result outside one sample range");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_i)
    else $error("register write stalled");

endmodule

bind six_row_shaped_vca_mixer_top svmix_checker #(
  .ROWS (ROWS)
) u_svmix_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_row_i    (out_o.out_row),
  .out_voice_i  (out_o.out_voice),
  .out_sample_i (out_o.out_sample),
  .cfg_valid_i  (cfg_i.valid),
  .cfg_ready_i  (cfg_i.ready)
);
